/* rtl/core/assert_macros.svh */
// Assertion macros shared by the thermostat controller RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define HCTC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define HCTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/hctc_pkg.sv */
// Types and fixed constants of the heat/cool thermostat controller.
// No dependencies; imported by hctc_step and the top level.
package hctc_pkg;

   // Item kinds
   localparam logic [2:0] KIND_CONTROL = 3'd0;
   localparam logic [2:0] KIND_MODE    = 3'd1;
   localparam logic [2:0] KIND_DOWN    = 3'd2;
   localparam logic [2:0] KIND_UP      = 3'd3;
   localparam logic [2:0] KIND_STOP    = 3'd4;
   localparam logic [2:0] KIND_HEATER  = 3'd5;

   // Operating modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_HEAT = 2'd1;
   localparam logic [1:0] MODE_COOL = 2'd2;
   localparam logic [1:0] MODE_AUTO = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SUMMER   = 2'd0;
   localparam logic [1:0] CSR_WINTER   = 2'd1;
   localparam logic [1:0] CSR_BOOST    = 2'd2;
   localparam logic [1:0] CSR_MIN_COOL = 2'd3;

   // Configuration reset values
   localparam logic [9:0] SUMMER_RESET   = 10'd600;
   localparam logic [9:0] WINTER_RESET   = 10'd400;
   localparam logic [9:0] BOOST_RESET    = 10'd520;
   localparam logic [6:0] MIN_COOL_RESET = 7'd25;

   // Fixed levels
   localparam logic [4:0] HEAT_MIN        = 5'd10;
   localparam logic [9:0] COOL_MANUAL_MAX = 10'd20;
   localparam logic [6:0] DUTY_MAX        = 7'd100;
   // 205 / 1024 approximates one fifth exactly for any 10-bit operand
   localparam logic [7:0] RECIP_FIVE      = 8'd205;

   typedef struct packed {
      logic [2:0] kind;
      logic [9:0] room_temp;
      logic [9:0] set_point;
      logic [9:0] outside_temp;
   } item_type;

   typedef struct packed {
      logic [9:0] summer_threshold;
      logic [9:0] winter_threshold;
      logic [9:0] boost_setpoint;
      logic [6:0] min_cool_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] heat;
      logic [9:0] cool;
      logic [2:0] band;
      logic [6:0] percent;
      logic [6:0] duty;
      logic       pin;
      logic [4:0] count;
   } state_type;

endpackage

/* rtl/core/hctc_step.sv */
// Next-state logic of the thermostat controller for one item.
// Depends on hctc_pkg; purely combinational, instantiated by the top level.
module hctc_step
   import hctc_pkg::*;
#(
   parameter int HEAT_PERIOD = 20,
   parameter int MAX_BAND    = 4
) (
   input  item_type  item,
   input  cfg_type   cfg,
   input  state_type cur,
   output state_type nxt
);

   localparam logic [4:0] HeatPeriodW = 5'(HEAT_PERIOD);
   localparam logic [7:0] HeatPeriodB = 8'(HEAT_PERIOD);
   localparam logic [2:0] MaxBandW    = 3'(MAX_BAND);

   logic [10:0] room_ext;
   logic [10:0] set_ext;
   logic [10:0] band_ext;
   logic        room_above;
   logic        set_above;
   logic        room_low;
   logic        room_high;
   logic [9:0]  diff_rs;
   logic [9:0]  diff_sr;
   logic [17:0] prod_five;
   logic [7:0]  quot_five;
   logic [7:0]  quot_sel;
   logic [4:0]  heat_clamped;
   logic [9:0]  min_cool_ext;
   logic [9:0]  cool_drv;
   logic [6:0]  duty_drv;
   logic [7:0]  heat_x5;
   logic [12:0] cool_x5;
   logic [6:0]  pct_heat;
   logic [6:0]  pct_cool;
   logic        auto_cold;

   // Compare room and set point, with the hysteresis band in tenths
   assign room_ext   = {1'b0, item.room_temp};
   assign set_ext    = {1'b0, item.set_point};
   assign band_ext   = 11'(cur.band) * 11'd10;
   assign room_above = item.room_temp > item.set_point;
   assign set_above  = item.set_point > item.room_temp;
   assign room_low   = (room_ext + band_ext) < set_ext;
   assign room_high  = room_ext > (set_ext + band_ext);
   assign diff_rs    = item.room_temp - item.set_point;
   assign diff_sr    = item.set_point - item.room_temp;
   assign auto_cold  = item.outside_temp < cfg.winter_threshold;

   // Divide the shortfall by five or ten through the reciprocal
   assign prod_five = 18'(diff_sr) * 18'(RECIP_FIVE);
   assign quot_five = prod_five[17:10];
   assign quot_sel  = auto_cold ? quot_five : {1'b0, quot_five[7:1]};

   // Clamp the heat level, then apply boost
   always_comb begin
      if (quot_sel > HeatPeriodB) begin
         heat_clamped = HeatPeriodW;
      end else begin
         heat_clamped = quot_sel[4:0];
      end
      if (heat_clamped < HEAT_MIN) begin
         heat_clamped = HEAT_MIN;
      end
      if (item.set_point > cfg.boost_setpoint) begin
         heat_clamped = HeatPeriodW;
      end
   end

   // Cooler level with its floor, and the saturated duty
   assign min_cool_ext = {3'b000, cfg.min_cool_level};
   assign cool_drv     = (diff_rs < min_cool_ext) ? min_cool_ext : diff_rs;
   assign duty_drv     = (cool_drv > 10'(DUTY_MAX)) ? DUTY_MAX : cool_drv[6:0];

   // Displayed percent for the manual modes
   assign heat_x5  = 8'(cur.heat) * 8'd5;
   assign cool_x5  = 13'(cur.cool) * 13'd5;
   assign pct_heat = (heat_x5 > 8'(DUTY_MAX)) ? DUTY_MAX : heat_x5[6:0];
   assign pct_cool = (cool_x5 > 13'(DUTY_MAX)) ? DUTY_MAX : cool_x5[6:0];

   // Apply the item to the state
   always_comb begin
      nxt = cur;
      case (item.kind)
         KIND_CONTROL: begin
            case (cur.mode)
               MODE_OFF: begin
                  nxt.heat    = '0;
                  nxt.cool    = '0;
                  nxt.percent = '0;
                  nxt.duty    = '0;
               end
               MODE_HEAT: begin
                  nxt.percent = pct_heat;
               end
               MODE_COOL: begin
                  nxt.pin     = 1'b0;
                  nxt.percent = pct_cool;
                  nxt.duty    = pct_cool;
               end
               default: begin
                  if (item.outside_temp > cfg.summer_threshold) begin
                     // Summer policy: cool when warm, fall back to minimum heat when cold
                     if (room_above) begin
                        nxt.heat = '0;
                        nxt.pin  = 1'b0;
                        nxt.cool = cool_drv;
                        nxt.duty = duty_drv;
                     end
                     if (room_low) begin
                        nxt.cool = '0;
                        nxt.heat = HEAT_MIN;
                        nxt.duty = '0;
                     end
                  end else if (auto_cold) begin
                     // Winter policy: heat on shortfall, shut down when far above
                     if (set_above) begin
                        nxt.heat = heat_clamped;
                        nxt.cool = '0;
                        nxt.duty = '0;
                     end
                     if (room_high) begin
                        nxt.heat    = '0;
                        nxt.cool    = '0;
                        nxt.percent = '0;
                        nxt.duty    = '0;
                        nxt.pin     = 1'b0;
                     end
                  end else begin
                     // Neutral season: heat or cool on the sign of the error
                     if (set_above) begin
                        nxt.heat = heat_clamped;
                        nxt.cool = '0;
                        nxt.duty = '0;
                     end else begin
                        nxt.heat = '0;
                        nxt.cool = cool_drv;
                        nxt.duty = duty_drv;
                     end
                  end
               end
            endcase
         end
         KIND_MODE: begin
            case (cur.mode)
               MODE_OFF:  nxt.mode = MODE_HEAT;
               MODE_HEAT: nxt.mode = MODE_COOL;
               MODE_COOL: begin
                  nxt.mode = MODE_AUTO;
                  nxt.pin  = 1'b0;
                  nxt.duty = '0;
               end
               default: begin
                  nxt.mode = MODE_HEAT;
                  nxt.duty = '0;
               end
            endcase
            nxt.heat    = '0;
            nxt.cool    = '0;
            nxt.percent = '0;
         end
         KIND_DOWN: begin
            case (cur.mode)
               MODE_HEAT: if (cur.heat != '0) nxt.heat = cur.heat - 5'd1;
               MODE_COOL: if (cur.cool != '0) nxt.cool = cur.cool - 10'd1;
               MODE_AUTO: if (cur.band != '0) nxt.band = cur.band - 3'd1;
               default: ;
            endcase
         end
         KIND_UP: begin
            case (cur.mode)
               MODE_HEAT: if (cur.heat < HeatPeriodW) nxt.heat = cur.heat + 5'd1;
               MODE_COOL: if (cur.cool < COOL_MANUAL_MAX) nxt.cool = cur.cool + 10'd1;
               MODE_AUTO: if (cur.band < MaxBandW) nxt.band = cur.band + 3'd1;
               default: ;
            endcase
         end
         KIND_STOP: begin
            nxt.mode    = MODE_OFF;
            nxt.pin     = 1'b0;
            nxt.heat    = '0;
            nxt.cool    = '0;
            nxt.percent = '0;
            nxt.duty    = '0;
         end
         KIND_HEATER: begin
            // Step the heater on/off pattern in heat or auto mode, wrap at the end of the period
            if (cur.count < HeatPeriodW) begin
               if (cur.mode inside {MODE_HEAT, MODE_AUTO}) begin
                  nxt.pin   = cur.count < cur.heat;
                  nxt.count = cur.count + 5'd1;
               end
            end else begin
               nxt.count = '0;
            end
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/heat_cool_thermostat_controller_top.sv */
// Top level of the heat/cool thermostat controller: channels, state and registers.
// Depends on hctc_pkg, hctc_step and assert_macros.svh.
//
// Use: each item on the req_ channel is one event (control tick with room,
// set-point and outside temperature, mode button, down, up, stop or heater
// tick). Every item yields exactly one result on the rsp_ channel, showing
// mode, heat and cool levels, cooler duty, heater pin, band and percent after
// that event. An item passes through an input register and then one stage of
// compare, add and constant-multiply logic into the state register, which is
// also the result register: rsp_valid rises when the state register takes the
// item from the input register, unless a held result stalls it there, and one
// item is taken every cycle while the receiver keeps up.
// When rsp_stall is high the result holds; the input register still takes
// one more item, then req_stall rises until the result is taken.
// Reset (synchronous, active high) clears the state and both valids and loads
// the configuration defaults. Write csr_ registers only while no item is in
// flight; a write takes effect at the edge where csr_write_en is high.
module heat_cool_thermostat_controller_top
   import hctc_pkg::*;
#(
   parameter int HEAT_PERIOD = 20,
   parameter int MAX_BAND    = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_kind,
   input  logic [9:0] req_room_temp,
   input  logic [9:0] req_set_point,
   input  logic [9:0] req_outside_temp,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_mode_now,
   output logic [4:0] rsp_heat_now,
   output logic [9:0] rsp_cool_now,
   output logic [6:0] rsp_cooler_duty,
   output logic       rsp_heater_on,
   output logic [2:0] rsp_band_now,
   output logic [6:0] rsp_shown_percent,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_data
);

`include "assert_macros.svh"

   item_type  item_ff;
   logic      in_valid_ff;
   logic      in_valid_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      advance;
   logic      fire;
   logic      req_take;
   logic      off_clean;
   logic      in_limits;

   // Handshake: the stage moves when the result slot is free or being taken
   assign advance      = !out_valid_ff || !rsp_stall;
   assign fire         = in_valid_ff && advance;
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the item while the input register is free to move
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff.kind         <= req_kind;
         item_ff.room_temp    <= req_room_temp;
         item_ff.set_point    <= req_set_point;
         item_ff.outside_temp <= req_outside_temp;
      end
   end

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SUMMER:   cfg_in.summer_threshold = csr_data;
            CSR_WINTER:   cfg_in.winter_threshold = csr_data;
            CSR_BOOST:    cfg_in.boost_setpoint   = csr_data;
            CSR_MIN_COOL: cfg_in.min_cool_level   = csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.summer_threshold <= SUMMER_RESET;
         cfg_ff.winter_threshold <= WINTER_RESET;
         cfg_ff.boost_setpoint   <= BOOST_RESET;
         cfg_ff.min_cool_level   <= MIN_COOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hctc_step #(
      .HEAT_PERIOD (HEAT_PERIOD),
      .MAX_BAND    (MAX_BAND)
   ) u_step (
      .item (item_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in)
   );

   // Advance the state; it doubles as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_mode_now      = state_ff.mode;
   assign rsp_heat_now      = state_ff.heat;
   assign rsp_cool_now      = state_ff.cool;
   assign rsp_cooler_duty   = state_ff.duty;
   assign rsp_heater_on     = state_ff.pin;
   assign rsp_band_now      = state_ff.band;
   assign rsp_shown_percent = state_ff.percent;

   // Conditions watched by the checks below
   assign off_clean = (state_ff.mode != MODE_OFF) ||
                      ((state_ff.heat == '0) && (state_ff.cool == '0) && (state_ff.duty == '0));
   assign in_limits = (state_ff.duty <= DUTY_MAX) && (32'(state_ff.band) <= MAX_BAND);

   // State moves only when an item goes through the stage
   `HCTC_ASSERT(a_state_hold, clock, reset, !fire |=> $stable(state_ff), "state changed without an item")
   // Off mode carries no heat, cool or duty
   `HCTC_ASSERT(a_off_clear, clock, reset, off_clean, "off mode with live levels")
   // Duty and band stay within their limits
   `HCTC_ASSERT(a_limits, clock, reset, in_limits, "duty or band out of range")
   // A stage that cannot move must hold off the sender
   `HCTC_ASSERT(a_no_overrun, clock, reset, (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff, "item dropped while stalled")

endmodule
